/* hw/rtl/tbh_pkg.sv */
// Package for the table byte hash: widths, register indexes, FSM states, command types.
package tbh_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TblDepth = 256;
  localparam int unsigned TblAw   = $clog2(TblDepth);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSeedOne   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSeedTwo   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeedThree = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeedFour  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHashSeed  = 3'd4;

  // Opcodes
  localparam logic OpBuild = 1'b0;
  localparam logic OpHash  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_BUILD
  } tbh_state_e;

  typedef logic [3:0][HashW-1:0] gen_words_t;

  // Controller to datapath
  typedef struct packed {
    logic             take_hash;  // hash request accepted: read table, latch flags
    logic             load_gen;   // build request accepted: seed the generators
    logic             step_gen;   // advance generators and write one table entry
    logic [TblAw-1:0] tbl_waddr;
    logic             fold;       // table word is ready: fold it into the hash
  } tbh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_block;  // fold would emit while the result slot is still occupied
  } tbh_status_t;

  // One combined LFSR113 step over all four generator words
  function automatic gen_words_t lfsr113_step(input gen_words_t g);
    gen_words_t  r;
    logic [31:0] fb;
    fb   = ((g[0] << 6) ^ g[0]) >> 13;
    r[0] = ((g[0] & 32'hFFFF_FFFE) << 18) ^ fb;
    fb   = ((g[1] << 2) ^ g[1]) >> 27;
    r[1] = ((g[1] & 32'hFFFF_FFF8) << 2) ^ fb;
    fb   = ((g[2] << 13) ^ g[2]) >> 21;
    r[2] = ((g[2] & 32'hFFFF_FFF0) << 7) ^ fb;
    fb   = ((g[3] << 3) ^ g[3]) >> 12;
    r[3] = ((g[3] & 32'hFFFF_FF80) << 13) ^ fb;
    return r;
  endfunction

endpackage

/* hw/rtl/tbh_if.sv */
// Valid/ready channel interfaces for byte requests and hash results.
interface tbh_in_if
  import tbh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [ByteW-1:0] data_byte;
  logic [ByteW-1:0] byte_index;
  logic             first_byte;
  logic             last_byte;

  modport source (output valid, opcode, data_byte, byte_index, first_byte, last_byte,
                  input ready);
  modport sink   (input valid, opcode, data_byte, byte_index, first_byte, last_byte,
                  output ready);
endinterface

interface tbh_out_if
  import tbh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HashW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

/* hw/rtl/tbh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tbh_ctrl.sv */
// Controller FSM for the table byte hash: sequences hash folds and table builds.
module tbh_ctrl
  import tbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_opcode_i,
  output logic        in_ready_o,
  input  tbh_status_t status_i,
  output tbh_cmd_t    cmd_o
);

  tbh_state_e       state_q, state_d;
  logic [TblAw-1:0] step_q, step_d;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.tbl_waddr = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OpHash) begin
            cmd_o.take_hash = 1'b1;
            state_d         = ST_HASH;
          end else begin
            cmd_o.load_gen = 1'b1;
            step_d         = '0;
            state_d        = ST_BUILD;
          end
        end
      end
      ST_HASH: begin
        if (!status_i.out_block) begin
          cmd_o.fold = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_BUILD: begin
        cmd_o.step_gen = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == TblAw'(TblDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A build request starts the sweep at entry zero
  a_build_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_opcode_i == OpBuild) |=> (state_q == ST_BUILD) && (step_q == '0))
    else $error("build did not start at entry zero");

  // The sweep walks entries in order without gaps
  a_build_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD) && (step_q != TblAw'(TblDepth - 1))
      |=> (state_q == ST_BUILD) && (step_q == $past(step_q) + 1'b1))
    else $error("build sweep skipped or stopped early");

  // A hash request always reaches the fold state
  a_hash_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_opcode_i == OpHash) |=> (state_q == ST_HASH))
    else $error("hash request lost");

  // Never fold while the result slot would be overwritten
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fold |-> !status_i.out_block)
    else $error("fold issued against a blocked result slot");

endmodule

/* hw/rtl/tbh_dpath.sv */
// Datapath for the table byte hash: config registers, generators, table RAM, hash fold.
module tbh_dpath
  import tbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [ByteW-1:0]   in_data_byte_i,
  input  logic [ByteW-1:0]   in_byte_index_i,
  input  logic               in_first_byte_i,
  input  logic               in_last_byte_i,
  input  tbh_cmd_t           cmd_i,
  output tbh_status_t        status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HashW-1:0]   out_hash_value_o
);

  logic [HashW-1:0] seed_one_q, seed_two_q, seed_three_q, seed_four_q, hash_seed_q;
  gen_words_t       gen_q, gen_d, gen_nx;
  logic [HashW-1:0] hash_q, hash_d, hash_base, tbl_rdata, tbl_wdata;
  logic [HashW-1:0] out_hash_q;
  logic             out_valid_q;
  logic             first_q, last_q;
  logic [TblAw-1:0] tbl_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_one_q   <= '0;
      seed_two_q   <= '0;
      seed_three_q <= '0;
      seed_four_q  <= '0;
      hash_seed_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSeedOne:   seed_one_q   <= cfg_data_i;
        RegSeedTwo:   seed_two_q   <= cfg_data_i;
        RegSeedThree: seed_three_q <= cfg_data_i;
        RegSeedFour:  seed_four_q  <= cfg_data_i;
        RegHashSeed:  hash_seed_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Generators: seeds below the minimum get the forcing bit
  assign gen_nx = lfsr113_step(gen_q);

  always_comb begin
    gen_d = gen_q;
    if (cmd_i.load_gen) begin
      gen_d[0] = (seed_one_q   < 32'd2)   ? (seed_one_q   | 32'h02) : seed_one_q;
      gen_d[1] = (seed_two_q   < 32'd8)   ? (seed_two_q   | 32'h08) : seed_two_q;
      gen_d[2] = (seed_three_q < 32'd16)  ? (seed_three_q | 32'h10) : seed_three_q;
      gen_d[3] = (seed_four_q  < 32'd128) ? (seed_four_q  | 32'h80) : seed_four_q;
    end else if (cmd_i.step_gen) begin
      gen_d = gen_nx;
    end
  end

  assign tbl_wdata = gen_nx[0] ^ gen_nx[1] ^ gen_nx[2] ^ gen_nx[3];
  assign tbl_raddr = in_byte_index_i + in_data_byte_i;

  tbh_ram #(
    .Width (HashW),
    .Depth (TblDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step_gen),
    .waddr_i (cmd_i.tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.take_hash),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // hash * 5 as shift-and-add
  assign hash_base = first_q ? hash_seed_q : hash_q;
  assign hash_d    = tbl_rdata ^ ((hash_base << 2) + hash_base);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= '0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      gen_q <= gen_d;
      if (cmd_i.take_hash) begin
        first_q <= in_first_byte_i;
        last_q  <= in_last_byte_i;
      end
      if (cmd_i.fold) begin
        hash_q <= hash_d;
      end
      if (cmd_i.fold && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold && last_q) begin
      out_hash_q <= hash_d;
    end
  end

  assign status_o.out_block = last_q && out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_hash_value_o   = out_hash_q;

  // A fold of a last byte always presents a result
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold && last_q |=> out_valid_q && (out_hash_q == $past(hash_d)))
    else $error("last byte fold produced no result");

  // A fold of a middle byte leaves the result slot alone
  a_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold && !last_q && !out_valid_q |=> !out_valid_q)
    else $error("result invented on a middle byte");

endmodule

/* hw/rtl/table_byte_hash32_lfsr_table.sv */
// Top level of the table-driven 32-bit byte hash with an LFSR113-built table.
//
// Table-driven 32-bit byte-stream hash. A build request (opcode 0) seeds four
// LFSR113 generators from registers 0..3 (each forced above its minimum) and
// writes 256 table words, one per cycle, into a single-port-write table RAM;
// the block is busy for the whole sweep after the build request is accepted. A
// hash request (opcode 1) folds one byte: hash = table[(byte_index +
// data_byte) & 0xFF] ^ (hash * 5), loading register 4 first when first_byte
// is set, and gives a result request on last_byte. Each hash request does the
// registered table read, then the fold. Results sit in an output register, so
// the next request is accepted while a result waits; a last-byte fold stalls
// only while the previous result is still untaken. Feed bytes last to first.
// Hashing before the first build reads an unwritten table and gives undefined
// values. Configuration writes are taken any cycle but should only happen
// while the block is idle.
module table_byte_hash32_lfsr_table
  import tbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  tbh_in_if.sink             in_chan,
  tbh_out_if.source          out_chan,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  tbh_cmd_t    cmd;
  tbh_status_t status;

  // Sequencing: idle / hash fold / build sweep
  tbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_opcode_i (in_chan.opcode),
    .in_ready_o  (in_chan.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Registers, generators, table and the hash recurrence
  tbh_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_data_byte_i   (in_chan.data_byte),
    .in_byte_index_i  (in_chan.byte_index),
    .in_first_byte_i  (in_chan.first_byte),
    .in_last_byte_i   (in_chan.last_byte),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_chan.valid),
    .out_ready_i      (out_chan.ready),
    .out_hash_value_o (out_chan.hash_value)
  );

endmodule
